// ===== rtl/lcd_nibble_write_sequencer_assert.svh =====
// Assertion helpers shared by the sequencer modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH
`define LCD_NIBBLE_WRITE_SEQUENCER_ASSERT_SVH

`ifndef SYNTH
`define LNWS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lnws check failed");
`define LNWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lnws check failed");
`else
`define LNWS_ASSERT_IMPL(label, ante, cons)
`define LNWS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/lnws_pkg.sv =====
package lnws_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 2;
    localparam int HOLD_W  = 14;
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int GROUP_W = 3;
    localparam int PHASE_W = 3;

    // Request kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_INIT  = 1'b1;

    // Hold times in microseconds
    localparam logic [HOLD_W-1:0] HOLD_MAX        = 14'd16000;
    localparam logic [HOLD_W-1:0] HOLD_POWER      = 14'd15000;
    localparam logic [HOLD_W-1:0] HOLD_WAKE_LONG  = 14'd4100;
    localparam logic [HOLD_W-1:0] HOLD_WAKE_SHORT = 14'd100;
    localparam logic [HOLD_W-1:0] HOLD_CMD_SHORT  = 14'd44;
    localparam logic [HOLD_W-1:0] HOLD_CMD_MID    = 14'd100;
    localparam logic [HOLD_W-1:0] HOLD_CLEAR      = 14'd1800;

    localparam logic [NIB_W-1:0] WAKE_NIBBLE = 4'h3;

    // Wake-up strobe phases
    localparam logic [PHASE_W-1:0] PH_WAKE_SET    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAKE_STROBE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WAKE_FALL   = 3'd2;

    // Byte write phases
    localparam logic [PHASE_W-1:0] PH_RISE_HI = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SHOW_HI = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FALL_HI = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RISE_LO = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SHOW_LO = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FALL_LO = 3'd5;

    localparam logic [GROUP_W-1:0] WAKE_LAST_GROUP = 3'd1;
    localparam logic [GROUP_W-1:0] INIT_LAST_GROUP = 3'd5;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_POWER,
        SEQ_WAKE,
        SEQ_BYTE
    } seq_state_t;

    typedef struct packed {
        logic              is_init;
        logic [BYTE_W-1:0] data_byte;
        logic              rs;
        logic [HOLD_W-1:0] hold;
    } cmd_t;

    typedef struct packed {
        logic [NIB_W-1:0]  nibble;
        logic              rs;
        logic              en;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } pin_state_t;

    // Instruction bytes of the power-up sequence, after the wake-up strobes
    function automatic logic [BYTE_W-1:0] init_byte(input logic [GROUP_W-1:0] grp);
        logic [BYTE_W-1:0] b;
        b = '0;
        unique case (grp)
            3'd0:    b = 8'h32;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h08;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h0C;
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [HOLD_W-1:0] init_hold(input logic [GROUP_W-1:0] grp);
        logic [HOLD_W-1:0] h;
        h = '0;
        unique case (grp)
            3'd0:    h = HOLD_CMD_MID;
            3'd1:    h = HOLD_CMD_SHORT;
            3'd2:    h = HOLD_CMD_SHORT;
            3'd3:    h = HOLD_CLEAR;
            3'd4:    h = HOLD_CMD_SHORT;
            3'd5:    h = HOLD_CMD_SHORT;
            default: h = '0;
        endcase
        return h;
    endfunction

endpackage

// ===== rtl/lnws_front.sv =====
module lnws_front
    import lnws_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], register_select[8], wait_us[22:9]
    input  logic        s_tuser,   // op
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);

    logic [HOLD_W-1:0] wait_raw;

    // Take an item whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Classify the request and clamp the hold
    assign wait_raw = s_tdata[22:9];

    always_comb
    begin
        push_cmd.is_init   = (s_tuser == OP_INIT);
        push_cmd.data_byte = s_tdata[7:0];
        push_cmd.rs        = s_tdata[8];
        push_cmd.hold      = (wait_raw > HOLD_MAX) ? HOLD_MAX : wait_raw;
    end

endmodule

// ===== rtl/lnws_queue.sv =====
`include "lcd_nibble_write_sequencer_assert.svh"
module lnws_queue
    import lnws_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `LNWS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_FULL)
    `LNWS_ASSERT_NEXT(a_push_counts, do_push && !do_pop, count_reg != '0)

endmodule

// ===== rtl/lnws_back.sv =====
`include "lcd_nibble_write_sequencer_assert.svh"
module lnws_back
    import lnws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_nonempty,
    input  cmd_t       q_head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output pin_state_t out_state
);

    seq_state_t         state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [GROUP_W-1:0] group_reg, group_next;
    logic               is_init_reg;
    logic [BYTE_W-1:0]  cmd_byte_reg;
    logic               cmd_rs_reg;
    logic [HOLD_W-1:0]  cmd_hold_reg;
    logic [NIB_W-1:0]   pin_nibble_reg;
    logic               pin_rs_reg;
    logic               pin_enable_reg;
    logic               out_valid_reg, out_valid_next;
    pin_state_t         out_reg;
    pin_state_t         emit;
    logic               slot_free, fire;
    logic [BYTE_W-1:0]  cur_byte;
    logic [HOLD_W-1:0]  cur_hold;

    assign slot_free = !out_valid_reg || out_ready;
    assign fire      = (state_reg != SEQ_IDLE) && slot_free;
    assign pop       = (state_reg == SEQ_IDLE) && q_nonempty;
    assign cur_byte  = is_init_reg ? init_byte(group_reg) : cmd_byte_reg;
    assign cur_hold  = is_init_reg ? init_hold(group_reg) : cmd_hold_reg;
    assign out_valid = out_valid_reg;
    assign out_state = out_reg;

    // Next state of the pin sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        group_next = group_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (pop)
                begin
                    state_next = q_head.is_init ? SEQ_POWER : SEQ_BYTE;
                    phase_next = '0;
                    group_next = '0;
                end
            end
            SEQ_POWER:
            begin
                if (fire)
                begin
                    state_next = SEQ_WAKE;
                end
            end
            SEQ_WAKE:
            begin
                if (fire)
                begin
                    if (phase_reg == PH_WAKE_FALL)
                    begin
                        phase_next = '0;
                        if (group_reg == WAKE_LAST_GROUP)
                        begin
                            state_next = SEQ_BYTE;
                            group_next = '0;
                        end
                        else
                        begin
                            group_next = group_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            SEQ_BYTE:
            begin
                if (fire)
                begin
                    if (phase_reg == PH_FALL_LO)
                    begin
                        phase_next = '0;
                        if (is_init_reg && group_reg != INIT_LAST_GROUP)
                        begin
                            group_next = group_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = SEQ_IDLE;
                            group_next = '0;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    // Pin state for the present step
    always_comb
    begin
        emit = '0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                emit = '0;
            end
            SEQ_POWER:
            begin
                emit.hold = HOLD_POWER;
            end
            SEQ_WAKE:
            begin
                emit.nibble = WAKE_NIBBLE;
                emit.rs     = 1'b0;
                emit.en     = (phase_reg == PH_WAKE_STROBE);
                emit.hold   = (group_reg == '0) ? HOLD_WAKE_LONG : HOLD_WAKE_SHORT;
            end
            SEQ_BYTE:
            begin
                emit.hold   = cur_hold;
                emit.nibble = pin_nibble_reg;
                emit.rs     = pin_rs_reg;
                emit.en     = pin_enable_reg;
                case (phase_reg)
                    PH_RISE_HI:
                    begin
                        emit.rs = is_init_reg ? 1'b0 : cmd_rs_reg;
                        emit.en = 1'b1;
                    end
                    PH_SHOW_HI:
                    begin
                        emit.nibble = cur_byte[7:4];
                    end
                    PH_FALL_HI:
                    begin
                        emit.en = 1'b0;
                    end
                    PH_RISE_LO:
                    begin
                        emit.en = 1'b1;
                    end
                    PH_SHOW_LO:
                    begin
                        emit.nibble = cur_byte[3:0];
                    end
                    PH_FALL_LO:
                    begin
                        emit.en   = 1'b0;
                        emit.last = !is_init_reg || (group_reg == INIT_LAST_GROUP);
                    end
                    default:
                    begin
                        emit = '0;
                    end
                endcase
            end
        endcase
    end

    // Hold the output item until taken
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            phase_reg      <= '0;
            group_reg      <= '0;
            is_init_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pin_nibble_reg <= '0;
            pin_rs_reg     <= 1'b0;
            pin_enable_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            group_reg     <= group_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                is_init_reg <= q_head.is_init;
            end
            if (fire)
            begin
                pin_nibble_reg <= emit.nibble;
                pin_rs_reg     <= emit.rs;
                pin_enable_reg <= emit.en;
            end
        end
    end

    // Latch the command payload and the outgoing pin state
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_byte_reg <= q_head.data_byte;
            cmd_rs_reg   <= q_head.rs;
            cmd_hold_reg <= q_head.hold;
        end
        if (fire)
        begin
            out_reg <= emit;
        end
    end

    `LNWS_ASSERT_IMPL(a_idle_clear, state_reg == SEQ_IDLE, phase_reg == '0 && group_reg == '0)
    `LNWS_ASSERT_NEXT(a_last_ends, fire && emit.last, state_reg == SEQ_IDLE)
    `LNWS_ASSERT_IMPL(a_write_single, state_reg == SEQ_BYTE && !is_init_reg, group_reg == '0)
    `LNWS_ASSERT_IMPL(a_wake_groups, state_reg == SEQ_WAKE, group_reg <= WAKE_LAST_GROUP)

endmodule

// ===== rtl/lcd_nibble_write_sequencer.sv =====
// Character LCD driver for a 4-bit bus.
// Input channel (s_*): one request per item. s_tuser selects a byte write or
// the power-up initialization; s_tdata carries the byte, the RS level and the
// hold in microseconds (clamped to 16000).
// Output channel (m_*): one item per timed pin state (D7..D4, RS, E, hold);
// m_tlast marks the final pin state of a request.
// A byte write gives 6 items, initialization gives 43.
// A request passes through the queue, the sequencer state register and the
// output register before its first pin state is valid. The back sequencer
// emits one pin state per cycle while m_tready stays high, and passes through
// its idle state to fetch each request from the queue.
// Requests wait in a short queue, so s_tready stays high while it has room
// even as the sequencer is busy.
// Reset clears the queue, the sequencer and its stored pin levels to zero; the output pin state is not reset.
// When m_tready is low the current pin state is held and the sequencer stops;
// the queue then fills and s_tready drops.
module lcd_nibble_write_sequencer
    import lnws_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], register_select[8], wait_us[22:9], pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_nibble[3:0], rs_level[4], enable_level[5],
                                   // hold_us[19:6], pad
    output logic        m_tlast
);

    logic       q_push, q_full, q_pop, q_nonempty;
    cmd_t       q_in_cmd, q_head;
    pin_state_t out_state;

    lnws_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_in_cmd)
    );

    lnws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    lnws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_state  (out_state)
    );

    // Pack the pin state onto the stream
    assign m_tdata = {4'b0000, out_state.hold, out_state.en, out_state.rs, out_state.nibble};
    assign m_tlast = out_state.last;

endmodule
